FILE: hdl/gps_binary_frame_checker_macros.svh
// Assertion helpers shared by the frame checker modules.
// Each macro expects a clock named clk_i and an active-low reset named rst_ni.
`ifndef GPS_BINARY_FRAME_CHECKER_MACROS_SVH
`define GPS_BINARY_FRAME_CHECKER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define GBFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define GBFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define GBFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gbfc_pkg.sv
package gbfc_pkg;

  // Configuration register file.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgFirstSync  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondSync = 1'd1;

  localparam logic [7:0] FirstSyncRst  = 8'hD0;
  localparam logic [7:0] SecondSyncRst = 8'hDD;

  // Sync byte values as held in the register file.
  typedef struct packed {
    logic [7:0] first_sync;
    logic [7:0] second_sync;
  } gbfc_cfg_t;

  // One result per received byte.
  typedef struct packed {
    logic       body_valid;
    logic [5:0] body_index;
    logic [7:0] body_byte;
    logic       frame_end;
    logic       frame_good;
  } gbfc_result_t;

  // Frame hunting phases.
  typedef enum logic [2:0] {
    PhHunt = 3'b001,
    PhSync = 3'b010,
    PhBody = 3'b100
  } gbfc_phase_e;

endpackage

FILE: hdl/gbfc_cfg_regs.sv
module gbfc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  output gbfc_pkg::gbfc_cfg_t           cfg_o
);
  import gbfc_pkg::*;

  logic [7:0] first_sync_q, first_sync_d;
  logic [7:0] second_sync_q, second_sync_d;

  // Decode the write request onto the addressed register.
  always_comb begin
    first_sync_d  = first_sync_q;
    second_sync_d = second_sync_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFirstSync:  first_sync_d  = cfg_data_i;
        CfgSecondSync: second_sync_d = cfg_data_i;
        default: begin
          first_sync_d  = first_sync_q;
          second_sync_d = second_sync_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q  <= FirstSyncRst;
      second_sync_q <= SecondSyncRst;
    end else begin
      first_sync_q  <= first_sync_d;
      second_sync_q <= second_sync_d;
    end
  end

  assign cfg_o.first_sync  = first_sync_q;
  assign cfg_o.second_sync = second_sync_q;

endmodule

FILE: hdl/gbfc_frame_core.sv
`include "gps_binary_frame_checker_macros.svh"

module gbfc_frame_core #(
  parameter int unsigned FRAME_LEN = 35
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             rx_byte_i,
  input  gbfc_pkg::gbfc_cfg_t    cfg_i,
  output gbfc_pkg::gbfc_result_t result_o
);
  import gbfc_pkg::*;

  // Index of the first check byte (the sums stop below it), and of the final body byte.
  localparam logic [6:0] SumEnd  = 7'(FRAME_LEN - 2);
  localparam logic [6:0] LastIdx = 7'(FRAME_LEN - 1);

  gbfc_phase_e  phase_q, phase_d;
  logic [7:0]   sum_first_q, sum_first_d;
  logic [7:0]   sum_second_q, sum_second_d;
  logic [5:0]   count_q, count_d;
  logic [7:0]   held_q, held_d;
  logic [6:0]   pos;

  assign pos = {1'b0, count_q};

  // Next state and the result for the current byte.
  always_comb begin
    phase_d      = phase_q;
    sum_first_d  = sum_first_q;
    sum_second_d = sum_second_q;
    count_d      = count_q;
    held_d       = held_q;
    result_o     = '0;
    case (phase_q)
      PhSync: begin
        if (rx_byte_i == cfg_i.second_sync) begin
          phase_d = PhBody;
        end else begin
          phase_d      = PhHunt;
          sum_first_d  = '0;
          sum_second_d = '0;
          count_d      = '0;
        end
      end
      PhBody: begin
        result_o.body_valid = 1'b1;
        result_o.body_index = count_q;
        result_o.body_byte  = rx_byte_i;
        if (pos < SumEnd) begin
          sum_first_d  = sum_first_q + rx_byte_i;
          sum_second_d = sum_second_q + sum_first_d;
        end else if (pos == SumEnd) begin
          held_d = rx_byte_i;
        end
        if (pos >= LastIdx) begin
          result_o.frame_end  = 1'b1;
          result_o.frame_good = (sum_first_q == held_q) && (sum_second_q == rx_byte_i);
          phase_d      = PhHunt;
          sum_first_d  = '0;
          sum_second_d = '0;
          count_d      = '0;
        end else begin
          count_d = count_q + 6'd1;
        end
      end
      default: begin
        phase_d = (rx_byte_i == cfg_i.first_sync) ? PhSync : PhHunt;
      end
    endcase
  end

  // Frame state advances once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      sum_first_q  <= '0;
      sum_second_q <= '0;
      count_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      sum_first_q  <= sum_first_d;
      sum_second_q <= sum_second_d;
      count_q      <= count_d;
    end
  end

  // The stored check byte is only read after it has been written.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      held_q <= held_d;
    end
  end

  `GBFC_ASSERT_IMPL(a_end_in_body, result_o.frame_end, result_o.body_valid,
                    "frame end outside a frame body")
  `GBFC_ASSERT_IMPL(a_end_at_last, result_o.frame_end,
                    {1'b0, result_o.body_index} == LastIdx,
                    "frame end at the wrong body index")
  `GBFC_ASSERT(a_count_range, pos <= LastIdx, "body count beyond the frame length")

endmodule

FILE: hdl/gps_binary_frame_checker.sv
// Framed byte stream checker with an 8-bit Fletcher check.
// Input channel: one received byte per request (in_valid_i, in_stall_o, rx_byte_i).
// Output channel: one result per accepted byte (out_valid_o, out_stall_i) carrying
// body_valid, body_index, body_byte, frame_end and frame_good.
// The block hunts for the two sync bytes, then echoes FRAME_LEN body bytes with
// their index; on the last one it flags frame end and whether the final two bytes
// match the running sums taken over the rest of the body.
// A byte accepted into the input register is processed into the result register
// and offered from then on. Throughput is one byte per cycle while the receiver
// does not stall; the frame state update is a single add pair and compare between
// the input register and the result register. The user must write the sync byte
// values via the configuration port only while idle; the block does not check it.
// Reset returns the hunt to the first sync byte, clears the sums and both stages,
// and loads the default sync bytes. While the receiver stalls, the result is held;
// the input register still takes one more request if empty, then in_stall_o rises.
`include "gps_binary_frame_checker_macros.svh"

module gps_binary_frame_checker #(
  parameter int unsigned FRAME_LEN = 35
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         body_valid_o,
  output logic [5:0]                   body_index_o,
  output logic [7:0]                   body_byte_o,
  output logic                         frame_end_o,
  output logic                         frame_good_o,
  input  logic                         cfg_we_i,
  input  logic [gbfc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);
  import gbfc_pkg::*;

  gbfc_cfg_t    cfg;
  gbfc_result_t result;
  gbfc_result_t result_q;
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  logic         advance;
  logic         step;

  // The output register can take a result when empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  gbfc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gbfc_frame_core #(
    .FRAME_LEN (FRAME_LEN)
  ) u_frame_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign body_valid_o = result_q.body_valid;
  assign body_index_o = result_q.body_index;
  assign body_byte_o  = result_q.body_byte;
  assign frame_end_o  = result_q.frame_end;
  assign frame_good_o = result_q.frame_good;

  `GBFC_ASSERT_NEXT(a_held_input_kept, in_valid_q && !advance,
                    in_valid_q && $stable(in_byte_q),
                    "pending input request lost while the output stalls")
  `GBFC_ASSERT_NEXT(a_step_gives_result, step, out_valid_q,
                    "processed byte did not reach the result register")
  `GBFC_ASSERT_IMPL(a_good_only_at_end, out_valid_q && result_q.frame_good,
                    result_q.frame_end, "frame good reported before frame end")

endmodule

FILE: test/gps_binary_frame_checker_tb.sv
module gps_binary_frame_checker_tb;
  import gbfc_pkg::*;

  localparam int unsigned FrameLen = 35;
  localparam int unsigned ItemsPerPhase = 270;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned HoldLen = 300;
  localparam int unsigned DrainLimit = 5000;
  localparam int unsigned TimeoutCycles = 200000;

  // Clock, reset and block ports.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic body_valid_o;
  logic [5:0] body_index_o;
  logic [7:0] body_byte_o;
  logic frame_end_o;
  logic frame_good_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CfgFirstSync;
  logic [7:0] cfg_data_i = 8'h00;

  // Byte stream waiting to be sent and frame results still owed by the block.
  logic [7:0] pending_bytes[$];
  gbfc_result_t expected_results[$];

  // Private copy of the sync registers and of the frame state.
  gbfc_cfg_t sync_cfg = '{first_sync: FirstSyncRst, second_sync: SecondSyncRst};
  gbfc_phase_e frame_phase = PhHunt;
  logic [7:0] fletcher_a = 8'h00;
  logic [7:0] fletcher_b = 8'h00;
  logic [5:0] body_pos = 6'd0;
  logic [7:0] check_lo = 8'h00;

  // Idling rates in percent and the long receiver hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_granted = 0;

  int unsigned fail_count = 0;

  gps_binary_frame_checker #(
    .FRAME_LEN(FrameLen)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .body_valid_o,
    .body_index_o,
    .body_byte_o,
    .frame_end_o,
    .frame_good_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Return to hunting with the sums and the count cleared.
  function automatic void clear_frame();
    frame_phase = PhHunt;
    fletcher_a = 8'h00;
    fletcher_b = 8'h00;
    body_pos = 6'd0;
  endfunction

  // Advance the frame state by one received byte and give the result it causes.
  function automatic gbfc_result_t frame_step(input logic [7:0] b);
    gbfc_result_t r;
    logic [5:0] pos;
    r = '0;
    case (frame_phase)
      PhSync: begin
        if (b == sync_cfg.second_sync) begin
          frame_phase = PhBody;
        end else begin
          clear_frame();
        end
      end
      PhBody: begin
        pos = body_pos;
        r.body_valid = 1'b1;
        r.body_index = pos;
        r.body_byte = b;
        if (int'(pos) < FrameLen - 2) begin
          fletcher_a = fletcher_a + b;
          fletcher_b = fletcher_b + fletcher_a;
        end else if (int'(pos) == FrameLen - 2) begin
          check_lo = b;
        end
        if (int'(pos) + 1 >= FrameLen) begin
          r.frame_end = 1'b1;
          r.frame_good = (fletcher_a == check_lo) && (fletcher_b == b);
          clear_frame();
        end else begin
          body_pos = pos + 6'd1;
        end
      end
      default: begin
        frame_phase = (b == sync_cfg.first_sync) ? PhSync : PhHunt;
      end
    endcase
    return r;
  endfunction

  // Sender: predict on each accepted request, then offer the next byte or idle.
  always @(posedge clk_i) begin : drive_bytes
    logic take;
    logic offer;
    take = rst_ni && in_valid_i && !in_stall_o;
    if (take) begin
      expected_results.push_back(frame_step(rx_byte_i));
      void'(pending_bytes.pop_front());
    end
    if (in_valid_i && !take) begin
      offer = 1'b1;
    end else begin
      offer = rst_ni && (pending_bytes.size() != 0) && ($urandom_range(99) >= send_idle_pct);
    end
    in_valid_i <= offer;
    if (offer) begin
      rx_byte_i <= pending_bytes[0];
    end
  end

  // Long hold-off of the receiver, counted here so that the sender keeps going.
  always @(posedge clk_i) begin : count_hold
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (holds_granted != holds_asked) begin
      hold_cycles <= HoldLen;
      holds_granted <= holds_granted + 1;
    end
  end

  // Receiver: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : collect_results
    gbfc_result_t seen;
    gbfc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {body_valid_o, body_index_o, body_byte_o, frame_end_o, frame_good_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: valid %0b index %0d byte %02h end %0b good %0b",
                   seen.body_valid, seen.body_index, seen.body_byte, seen.frame_end,
                   seen.frame_good);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen.body_valid !== want.body_valid || seen.body_index !== want.body_index ||
            seen.body_byte !== want.body_byte || seen.frame_end !== want.frame_end ||
            seen.frame_good !== want.frame_good) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected valid %0b index %0d byte %02h end %0b good %0b",
                     want.body_valid, want.body_index, want.body_byte, want.frame_end,
                     want.frame_good);
            $display("          actual   valid %0b index %0d byte %02h end %0b good %0b",
                     seen.body_valid, seen.body_index, seen.body_byte, seen.frame_end,
                     seen.frame_good);
          end
        end
      end
    end
    out_stall_i <= (hold_cycles != 0) || ($urandom_range(99) < stall_pct);
  end

  // Wait until every byte is sent and every result has come back or the drain limit runs out, then settle.
  task automatic drain();
    wait (pending_bytes.size() == 0);
    for (int n = 0; n < DrainLimit && expected_results.size() != 0; n++) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Write one sync register and keep the private copy in step.
  task automatic write_sync(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgFirstSync) begin
      sync_cfg.first_sync = val;
    end else begin
      sync_cfg.second_sync = val;
    end
  endtask

  // A complete frame with valid check bytes, optionally with one byte spoilt.
  task automatic queue_frame(input bit spoil);
    logic [7:0] body[FrameLen];
    logic [7:0] a;
    logic [7:0] c;
    int unsigned k;
    a = 8'h00;
    c = 8'h00;
    for (int i = 0; i < FrameLen - 2; i++) begin
      k = $urandom_range(9);
      body[i] = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
      a = a + body[i];
      c = c + a;
    end
    body[FrameLen-2] = a;
    body[FrameLen-1] = c;
    if (spoil) begin
      k = $urandom_range(FrameLen - 1);
      body[k] = body[k] ^ 8'($urandom_range(255, 1));
    end
    pending_bytes.push_back(sync_cfg.first_sync);
    pending_bytes.push_back(sync_cfg.second_sync);
    for (int i = 0; i < FrameLen; i++) begin
      pending_bytes.push_back(body[i]);
    end
  endtask

  // Mostly well-formed frames, the rest noise and broken sync pairs.
  task automatic queue_stream(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_frame($urandom_range(3) == 0);
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1)) pending_bytes.push_back(8'($urandom));
      end else begin
        pending_bytes.push_back(sync_cfg.first_sync);
        pending_bytes.push_back(($urandom_range(1) == 0) ? sync_cfg.first_sync :
                                8'($urandom));
      end
    end
  endtask

  // Phases: each after the first changes the sync bytes; each sets the idling pattern.
  initial begin : run_phases
    logic [7:0] first_vals[NumPhases];
    logic [7:0] second_vals[NumPhases];
    first_vals = '{8'hD0, 8'h00, 8'hFF, 8'h7E, 8'($urandom)};
    second_vals = '{8'hDD, 8'hFF, 8'h00, 8'h7E, 8'($urandom)};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      if (ph != 0) begin
        write_sync(CfgFirstSync, first_vals[ph]);
        write_sync(CfgSecondSync, second_vals[ph]);
      end
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 49; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 49; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase

      if (ph == 0) begin
        // Byte extremes, a wrong second sync byte, and a second first sync byte
        // that must not restart the hunt.
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(FirstSyncRst);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(FirstSyncRst);
        pending_bytes.push_back(FirstSyncRst);
        pending_bytes.push_back(SecondSyncRst);
        pending_bytes.push_back(FirstSyncRst);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(SecondSyncRst);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'hAA);
        // Hold the receiver off while the sender keeps offering.
        holds_asked++;
      end
      queue_stream(ItemsPerPhase);

      if (ph == 1) begin
        // Leave a frame half collected across the next register change.
        pending_bytes.push_back(sync_cfg.first_sync);
        pending_bytes.push_back(sync_cfg.second_sync);
        repeat (10) pending_bytes.push_back(8'($urandom));
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", expected_results.size());
    end
    if (fail_count == 0) begin
      $display("PASS gps_binary_frame_checker");
    end else begin
      $display("FAIL gps_binary_frame_checker");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin : watchdog
    #(TimeoutCycles * 4);
    $display("FAIL gps_binary_frame_checker");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/gbfc_pkg.sv
hdl/gbfc_cfg_regs.sv
hdl/gbfc_frame_core.sv
hdl/gps_binary_frame_checker.sv
test/gps_binary_frame_checker_tb.sv
